// File: rtl/xss_pkg.sv
package xss_pkg;

   localparam logic [63:0] SMALL_MULT = 64'd2685821657736338717;
   localparam logic [63:0] BANK_MULT  = 64'd1181783497276652981;

   localparam int BANK_WORDS = 16;
   localparam int PTR_W      = 4;

   // configuration register indexes
   localparam logic CSR_BANK_MODE = 1'b0;
   localparam logic CSR_FALLBACK  = 1'b1;

   // multiply sequence steps
   localparam logic [1:0] MUL_STEP_LO  = 2'd0;
   localparam logic [1:0] MUL_STEP_MA  = 2'd1;
   localparam logic [1:0] MUL_STEP_MB  = 2'd2;
   localparam logic [1:0] MUL_STEP_END = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SMALL = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_BRD   = 5'b01000,
      ST_BUPD  = 5'b10000
   } state_type;

   typedef struct packed {
      logic       advance;
      logic [1:0] step;
   } mul_ctl_type;

   function automatic logic [63:0] xs64_step(input logic [63:0] x);
      logic [63:0] t;
      t = x ^ (x >> 12);
      t = t ^ (t << 25);
      t = t ^ (t >> 27);
      return t;
   endfunction

   function automatic logic [63:0] bank_mix(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] tb;
      logic [63:0] ta;
      tb = b ^ (b << 31);
      tb = tb ^ (tb >> 11);
      ta = a ^ (a >> 30);
      return ta ^ tb;
   endfunction

endpackage

// File: rtl/xss_mul.sv
module xss_mul
   import xss_pkg::*;
(
   input  logic        clock,
   input  mul_ctl_type ctl,
   input  logic [63:0] operand,
   input  logic [63:0] factor,
   output logic [63:0] product
);

   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [63:0] acc_ff;
   logic [63:0] acc_in;

   // low 64 bits of a 64x64 product from three 32x32 partial products
   always_comb begin
      op_a   = operand[31:0];
      op_b   = factor[31:0];
      acc_in = acc_ff;
      case (ctl.step)
         MUL_STEP_LO: begin
            acc_in = 64'd0;
         end
         MUL_STEP_MA: begin
            op_b   = factor[63:32];
            acc_in = prod_ff;
         end
         MUL_STEP_MB: begin
            op_a   = operand[63:32];
            acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
      prod_in = 64'(op_a) * 64'(op_b);
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   assign product = acc_ff + {prod_ff[31:0], 32'd0};

endmodule

// File: rtl/xorshift_star_random_generator.sv
// Random word source: xorshift64* (csr register 0 = 0) or xorshift1024*
// (register 0 = 1), one 64-bit raw word per request. A nonzero seed_value
// reseeds first; a zero seed with a still-zero state loads fallback_seed
// (register 1). Every output goes through one shared 32x32 multiplier that
// forms each 64-bit product from three partial products; a bank-mode draw
// first reads two bank words and writes their mix back, and a bank-mode
// reseed first fills the bank by sixteen small draws. The request side
// stalls while an item is in flight; a finished word waits in the output
// register, and the next request is taken meanwhile.
module xorshift_star_random_generator
   import xss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_random_word,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   state_type        state_ff, state_in;
   logic [1:0]       mul_step_ff, mul_step_in;
   logic             fill_ff, fill_in;
   logic [PTR_W-1:0] fill_idx_ff, fill_idx_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [63:0]      small_ff, small_in;
   logic [63:0]      mul_x_ff, mul_x_in;
   logic             mul_bank_ff, mul_bank_in;
   logic             mode_ff;
   logic [63:0]      fallback_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_word_ff, rsp_word_in;

   logic [63:0]           bank_mem [BANK_WORDS];
   logic [BANK_WORDS-1:0] bank_vld_ff, bank_vld_in;
   logic [63:0]           rd_a_ff, rd_b_ff;
   logic                  rd_a_vld_ff, rd_b_vld_ff;
   logic                  bank_we;
   logic [PTR_W-1:0]      bank_waddr;
   logic [63:0]           bank_wdata;
   logic                  bank_re;

   mul_ctl_type mul_ctl;
   logic [63:0] mul_result;
   logic [63:0] stepped;
   logic [63:0] word_a, word_b, mixed;
   logic        accept, out_free, do_load;
   logic [63:0] load_value;

   xss_mul u_mul (
      .clock   (clock),
      .ctl     (mul_ctl),
      .operand (mul_x_ff),
      .factor  (mul_bank_ff ? BANK_MULT : SMALL_MULT),
      .product (mul_result)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;
   assign csr_ready       = 1'b1;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign do_load    = (req_seed_value != 64'd0) || (small_ff == 64'd0);
   assign load_value = (req_seed_value != 64'd0) ? req_seed_value : fallback_ff;
   assign stepped    = xs64_step(small_ff);
   assign word_a     = rd_a_vld_ff ? rd_a_ff : 64'd0;
   assign word_b     = rd_b_vld_ff ? rd_b_ff : 64'd0;
   assign mixed      = bank_mix(word_a, word_b);

   assign mul_ctl.advance = (state_ff == ST_MUL) && (mul_step_ff != MUL_STEP_END);
   assign mul_ctl.step    = mul_step_ff;

   always_comb begin
      state_in     = state_ff;
      mul_step_in  = mul_step_ff;
      fill_in      = fill_ff;
      fill_idx_in  = fill_idx_ff;
      ptr_in       = ptr_ff;
      small_in     = small_ff;
      mul_x_in     = mul_x_ff;
      mul_bank_in  = mul_bank_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      bank_vld_in  = bank_vld_ff;
      bank_we      = 1'b0;
      bank_waddr   = ptr_ff;
      bank_wdata   = mixed;
      bank_re      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            mul_step_in = MUL_STEP_LO;
            if (accept) begin
               if (do_load) begin
                  small_in = load_value;
               end
               if (mode_ff && do_load) begin
                  fill_in     = 1'b1;
                  fill_idx_in = '0;
                  state_in    = ST_SMALL;
               end else if (mode_ff) begin
                  state_in = ST_BRD;
               end else begin
                  state_in = ST_SMALL;
               end
            end
         end
         ST_SMALL: begin
            small_in    = stepped;
            mul_x_in    = stepped;
            mul_bank_in = 1'b0;
            mul_step_in = MUL_STEP_LO;
            state_in    = ST_MUL;
         end
         ST_BRD: begin
            bank_re  = 1'b1;
            ptr_in   = ptr_ff + PTR_W'(1);
            state_in = ST_BUPD;
         end
         ST_BUPD: begin
            bank_we              = 1'b1;
            bank_vld_in[ptr_ff]  = 1'b1;
            mul_x_in             = mixed;
            mul_bank_in          = 1'b1;
            mul_step_in          = MUL_STEP_LO;
            state_in             = ST_MUL;
         end
         ST_MUL: begin
            if (mul_step_ff != MUL_STEP_END) begin
               mul_step_in = mul_step_ff + 2'd1;
            end else if (fill_ff) begin
               bank_we                  = 1'b1;
               bank_waddr               = fill_idx_ff;
               bank_wdata               = mul_result;
               bank_vld_in[fill_idx_ff] = 1'b1;
               mul_step_in              = MUL_STEP_LO;
               fill_idx_in              = fill_idx_ff + PTR_W'(1);
               if (fill_idx_ff == PTR_W'(BANK_WORDS - 1)) begin
                  fill_in  = 1'b0;
                  ptr_in   = '0;
                  state_in = ST_BRD;
               end else begin
                  state_in = ST_SMALL;
               end
            end else if (out_free) begin
               rsp_word_in  = mul_result;
               rsp_valid_in = 1'b1;
               mul_step_in  = MUL_STEP_LO;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_step_ff  <= MUL_STEP_LO;
         fill_ff      <= 1'b0;
         fill_idx_ff  <= '0;
         ptr_ff       <= '0;
         small_ff     <= 64'd0;
         bank_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         fallback_ff  <= 64'd1;
      end else begin
         state_ff     <= state_in;
         mul_step_ff  <= mul_step_in;
         fill_ff      <= fill_in;
         fill_idx_ff  <= fill_idx_in;
         ptr_ff       <= ptr_in;
         small_ff     <= small_in;
         bank_vld_ff  <= bank_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BANK_MODE: mode_ff     <= csr_wdata[0];
               CSR_FALLBACK:  fallback_ff <= csr_wdata;
               default:       mode_ff     <= mode_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_x_ff    <= mul_x_in;
      mul_bank_ff <= mul_bank_in;
      rsp_word_ff <= rsp_word_in;
   end

   // bank memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (bank_we) begin
         bank_mem[bank_waddr] <= bank_wdata;
      end
      if (bank_re) begin
         rd_a_ff     <= bank_mem[ptr_ff];
         rd_b_ff     <= bank_mem[ptr_ff + PTR_W'(1)];
         rd_a_vld_ff <= bank_vld_ff[ptr_ff];
         rd_b_vld_ff <= bank_vld_ff[ptr_ff + PTR_W'(1)];
      end
   end

`ifndef ASSERT_OFF
   a_rsp_from_mul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_MUL))
      else $error("result raised outside the multiply finish");

   a_fill_scope: assert property (@(posedge clock) disable iff (reset)
      fill_ff |-> (state_ff == ST_SMALL || state_ff == ST_MUL))
      else $error("bank fill active outside small draw or multiply");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (mul_step_ff == MUL_STEP_LO))
      else $error("multiply step not cleared in idle");

   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && mul_step_ff == MUL_STEP_END && !fill_ff && !out_free)
      |=> (state_ff == ST_MUL && $stable(mul_result)))
      else $error("finished product lost while the output is stalled");
`endif

endmodule
